// File: rtl/core/quaternion_orientation_filter_assert.svh
// ---------------------------------------------------------------------------
// quaternion orientation filter assertion macros
// implication and next-cycle implication checks, removable with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ORIENTATION_FILTER_ASSERT_SVH
`define QUATERNION_ORIENTATION_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QOF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qof assertion failed");
`define QOF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qof assertion failed");
`else
`define QOF_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define QOF_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/qof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qof_pkg
// widths, codes and shared types of the quaternion orientation filter
// ---------------------------------------------------------------------------
package qof_pkg;

    localparam int QW     = 32;   // quaternion and unit vector, Q1.30
    localparam int AW     = 36;   // multiplier operand a and term results
    localparam int BW     = 32;   // multiplier operand b
    localparam int NW     = 38;   // normalizer input
    localparam int GW     = 16;   // sensor fields
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 24;

    localparam logic signed [QW-1:0] ONE_Q30 = 32'sh4000_0000;

    localparam logic [CFG_IW-1:0] CFG_BETA   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_PERIOD = 2'd1;

    localparam logic [4:0] STEP_GRAD_END = 5'd11;
    localparam logic [4:0] STEP_INTEG    = 5'd12;
    localparam logic [4:0] STEP_LAST     = 5'd23;

    typedef enum logic [2:0] {
        S_IDLE, S_ANORM, S_ISSUE, S_WAIT, S_SNORM, S_QNORM, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DIV, N_DST
    } t_nstate;

    typedef enum logic [1:0] {RND_12, RND_16, RND_24, RND_30} t_rnd;

    typedef enum logic [2:0] {
        WB_SET, WB_F1, WB_F2, WB_SSUB, WB_SADD, WB_D, WB_RATE, WB_QN
    } t_wb;

    typedef struct packed {
        logic                 vld;
        logic signed [AW-1:0] a;
        logic signed [BW-1:0] b;
        logic                 neg;
        logic                 first;
        logic                 last;
        t_rnd                 rnd;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic ok;
    } t_norm_sts;

    typedef logic signed [NW-1:0] t_nvec [4];
    typedef logic signed [QW-1:0] t_qvec [4];

endpackage
`default_nettype wire

// File: rtl/core/qof_imu_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qof_imu_if
// imu sample channel: gyro and accel triplets with valid/ready
// ---------------------------------------------------------------------------
interface qof_imu_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source(output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                   input ready);
    modport sink(input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/core/qof_quat_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qof_quat_if
// quaternion result channel with valid/ready
// ---------------------------------------------------------------------------
interface qof_quat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

// File: rtl/core/quaternion_orientation_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quaternion_orientation_filter
// gradient-descent imu orientation update in fixed point, q1.30 quaternion
// ---------------------------------------------------------------------------
// usage
//   i_imu carries one gyro/accel sample per transaction, o_quat returns the
//   updated orientation quaternion, one transaction out for each one in.
//   i_cfg_we/i_cfg_idx/i_cfg_data write beta_gain (index 0) and
//   sample_period (index 1); write only while the block is idle.
// throughput and sequence
//   one sample at a time; i_imu.ready is high only when idle, from the cycle
//   after the result leaves. each sample passes through the normalizer for
//   the accel, the gradient and the quaternion, and runs 24 steps through
//   the shared three-stage multiplier; a zero accel skips the gradient terms
//   and their normalizer pass.
// reset
//   synchronous, active low; orientation returns to identity, beta_gain to
//   6554 and sample_period to 167772.
// stall
//   the result holds on o_quat until taken; no new sample is taken meanwhile.
// ---------------------------------------------------------------------------
`include "quaternion_orientation_filter_assert.svh"
module quaternion_orientation_filter import qof_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    qof_imu_if.sink           i_imu,
    qof_quat_if.source        o_quat
);

    t_state               r_state, n_state;
    logic [15:0]          r_beta;
    logic [23:0]          r_period;
    t_qvec                r_q;
    logic signed [GW-1:0] r_g [3];
    logic signed [GW-1:0] r_a [3];
    logic signed [QW-1:0] r_au [2];
    logic signed [AW-1:0] r_w, r_f1, r_f2;
    logic signed [AW-1:0] r_s [4];
    logic signed [AW-1:0] r_d [4];
    logic signed [NW-1:0] r_qn [4];
    logic [4:0]           r_step;
    logic [1:0]           r_prod;
    logic                 r_nstart;

    logic signed [AW-1:0] w_qa [4];
    logic signed [BW-1:0] w_gb [3];
    logic signed [AW-1:0] w_a;
    logic signed [BW-1:0] w_b;
    logic                 w_neg;
    logic [1:0]           w_plast;
    t_rnd                 w_rnd;
    t_wb                  w_wb;
    logic [1:0]           w_idx;
    t_mul_req             w_req;
    logic                 w_mul_vld;
    logic signed [AW-1:0] w_t;
    logic signed [AW:0]   w_diff, w_sum;
    logic signed [AW+1:0] w_f1, w_f2, w_ssub, w_sadd;
    t_nvec                w_nvec;
    t_qvec                w_nvout;
    t_norm_sts            w_nsts;

    always_comb begin
        for (int i = 0; i < 4; i++) w_qa[i] = AW'(r_q[i]);
        for (int i = 0; i < 3; i++) w_gb[i] = BW'(r_g[i]);
    end

    // operand decode for each term of the update
    always_comb begin
        w_a     = '0;
        w_b     = '0;
        w_neg   = 1'b0;
        w_plast = 2'd0;
        w_rnd   = RND_30;
        w_wb    = WB_SET;
        w_idx   = 2'd0;
        unique case (r_step) inside
            5'd0:  begin w_a = w_qa[1]; w_b = r_q[3]; end
            5'd1:  begin w_a = w_qa[0]; w_b = r_q[2]; w_wb = WB_F1; end
            5'd2:  begin w_a = w_qa[0]; w_b = r_q[1]; end
            5'd3:  begin w_a = w_qa[2]; w_b = r_q[3]; w_wb = WB_F2; end
            5'd4:  begin w_a = r_f2; w_b = r_q[1]; end
            5'd5:  begin w_a = r_f1; w_b = r_q[2]; w_wb = WB_SSUB; w_idx = 2'd0; end
            5'd6:  begin w_a = r_f1; w_b = r_q[3]; end
            5'd7:  begin w_a = r_f2; w_b = r_q[0]; w_wb = WB_SADD; w_idx = 2'd1; end
            5'd8:  begin w_a = r_f2; w_b = r_q[3]; end
            5'd9:  begin w_a = r_f1; w_b = r_q[0]; w_wb = WB_SSUB; w_idx = 2'd2; end
            5'd10: begin w_a = r_f1; w_b = r_q[1]; end
            5'd11: begin w_a = r_f2; w_b = r_q[2]; w_wb = WB_SADD; w_idx = 2'd3; end
            5'd12: begin
                w_plast = 2'd2; w_rnd = RND_12; w_wb = WB_D; w_idx = 2'd0; w_neg = 1'b1;
                case (r_prod)
                    2'd0:    begin w_a = w_qa[1]; w_b = w_gb[0]; end
                    2'd1:    begin w_a = w_qa[2]; w_b = w_gb[1]; end
                    default: begin w_a = w_qa[3]; w_b = w_gb[2]; end
                endcase
            end
            5'd13: begin
                w_plast = 2'd2; w_rnd = RND_12; w_wb = WB_D; w_idx = 2'd1;
                case (r_prod)
                    2'd0:    begin w_a = w_qa[0]; w_b = w_gb[0]; end
                    2'd1:    begin w_a = w_qa[2]; w_b = w_gb[2]; end
                    default: begin w_a = w_qa[3]; w_b = w_gb[1]; w_neg = 1'b1; end
                endcase
            end
            5'd14: begin
                w_plast = 2'd2; w_rnd = RND_12; w_wb = WB_D; w_idx = 2'd2;
                case (r_prod)
                    2'd0:    begin w_a = w_qa[0]; w_b = w_gb[1]; end
                    2'd1:    begin w_a = w_qa[1]; w_b = w_gb[2]; w_neg = 1'b1; end
                    default: begin w_a = w_qa[3]; w_b = w_gb[0]; end
                endcase
            end
            5'd15: begin
                w_plast = 2'd2; w_rnd = RND_12; w_wb = WB_D; w_idx = 2'd3;
                case (r_prod)
                    2'd0:    begin w_a = w_qa[0]; w_b = w_gb[2]; end
                    2'd1:    begin w_a = w_qa[1]; w_b = w_gb[1]; end
                    default: begin w_a = w_qa[2]; w_b = w_gb[0]; w_neg = 1'b1; end
                endcase
            end
            [5'd16:5'd19]: begin
                w_idx = r_step[1:0]; w_a = r_s[r_step[1:0]];
                w_b = $signed(BW'(r_beta)); w_rnd = RND_16; w_wb = WB_RATE;
            end
            [5'd20:5'd23]: begin
                w_idx = r_step[1:0]; w_a = r_d[r_step[1:0]];
                w_b = $signed(BW'(r_period)); w_rnd = RND_24; w_wb = WB_QN;
            end
            default: ;
        endcase
    end

    assign w_req.vld   = r_state == S_ISSUE;
    assign w_req.a     = w_a;
    assign w_req.b     = w_b;
    assign w_req.neg   = w_neg;
    assign w_req.first = r_prod == 2'd0;
    assign w_req.last  = r_prod == w_plast;
    assign w_req.rnd   = w_rnd;

    qof_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_vld   (w_mul_vld),
        .o_res   (w_t)
    );

    always_comb begin
        unique case (r_state)
            S_ANORM: begin
                for (int i = 0; i < 3; i++) w_nvec[i] = NW'(r_a[i]);
                w_nvec[3] = '0;
            end
            S_SNORM: begin
                for (int i = 0; i < 4; i++) w_nvec[i] = NW'(r_s[i]);
            end
            default: begin
                for (int i = 0; i < 4; i++) w_nvec[i] = r_qn[i];
            end
        endcase
    end

    qof_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec   (w_nvec),
        .o_sts   (w_nsts),
        .o_vec   (w_nvout)
    );

    assign w_diff = (AW+1)'(r_w) - (AW+1)'(w_t);
    assign w_sum  = (AW+1)'(r_w) + (AW+1)'(w_t);
    assign w_ssub = (AW+2)'(w_diff) <<< 1;
    assign w_sadd = (AW+2)'(w_sum) <<< 1;
    assign w_f1   = w_ssub - (AW+2)'(r_au[0]);
    assign w_f2   = w_sadd - (AW+2)'(r_au[1]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_imu.valid) n_state = S_ANORM;
            S_ANORM: if (w_nsts.done) n_state = S_ISSUE;
            S_ISSUE: if (r_prod == w_plast) n_state = S_WAIT;
            S_WAIT: begin
                if (w_mul_vld) begin
                    if (r_step == STEP_GRAD_END)  n_state = S_SNORM;
                    else if (r_step == STEP_LAST) n_state = S_QNORM;
                    else                          n_state = S_ISSUE;
                end
            end
            S_SNORM: if (w_nsts.done) n_state = S_ISSUE;
            S_QNORM: if (w_nsts.done) n_state = S_OUT;
            S_OUT:   if (o_quat.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nstart <= 1'b0;
            r_step   <= 5'd0;
            r_prod   <= 2'd0;
            r_beta   <= 16'd6554;
            r_period <= 24'd167772;
            r_q[0]   <= ONE_Q30;
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
        end else begin
            r_state  <= n_state;
            r_nstart <= (n_state != r_state) &&
                        (n_state == S_ANORM || n_state == S_SNORM || n_state == S_QNORM);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BETA:   r_beta   <= i_cfg_data[15:0];
                    CFG_PERIOD: r_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_ANORM && w_nsts.done) begin
                // zero accel skips the gradient terms
                r_step <= w_nsts.ok ? 5'd0 : STEP_INTEG;
                r_prod <= 2'd0;
            end
            if (r_state == S_ISSUE) begin
                r_prod <= (r_prod == w_plast) ? 2'd0 : r_prod + 2'd1;
            end
            if (r_state == S_WAIT && w_mul_vld) begin
                r_step <= r_step + 5'd1;
            end
            if (r_state == S_QNORM && w_nsts.done) begin
                if (w_nsts.ok) begin
                    for (int i = 0; i < 4; i++) r_q[i] <= w_nvout[i];
                end else begin
                    r_q[0] <= ONE_Q30;
                    r_q[1] <= '0;
                    r_q[2] <= '0;
                    r_q[3] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_imu.valid) begin
            r_g[0] <= i_imu.gyro_x;
            r_g[1] <= i_imu.gyro_y;
            r_g[2] <= i_imu.gyro_z;
            r_a[0] <= i_imu.accel_x;
            r_a[1] <= i_imu.accel_y;
            r_a[2] <= i_imu.accel_z;
        end
        if (r_state == S_ANORM && w_nsts.done) begin
            r_au[0] <= w_nvout[0];
            r_au[1] <= w_nvout[1];
            if (!w_nsts.ok) begin
                for (int i = 0; i < 4; i++) r_s[i] <= '0;
            end
        end
        if (r_state == S_SNORM && w_nsts.done) begin
            for (int i = 0; i < 4; i++) r_s[i] <= w_nsts.ok ? AW'(w_nvout[i]) : '0;
        end
        if (r_state == S_WAIT && w_mul_vld) begin
            unique case (w_wb)
                WB_SET:  r_w <= w_t;
                WB_F1:   r_f1 <= w_f1[AW-1:0];
                WB_F2:   r_f2 <= w_f2[AW-1:0];
                WB_SSUB: r_s[w_idx] <= w_ssub[AW-1:0];
                WB_SADD: r_s[w_idx] <= w_sadd[AW-1:0];
                WB_D:    r_d[w_idx] <= w_t;
                WB_RATE: r_d[w_idx] <= r_d[w_idx] - w_t;
                WB_QN:   r_qn[w_idx] <= NW'(r_q[w_idx]) + NW'(w_t);
                default: ;
            endcase
        end
    end

    assign i_imu.ready   = r_state == S_IDLE;
    assign o_quat.valid  = r_state == S_OUT;
    assign o_quat.quat_w = r_q[0];
    assign o_quat.quat_x = r_q[1];
    assign o_quat.quat_y = r_q[2];
    assign o_quat.quat_z = r_q[3];

    `QOF_ASSERT_IMP(a_quat_range, i_clk, i_rst_n, o_quat.valid,
        r_q[0] <= ONE_Q30 && r_q[0] >= -ONE_Q30 && r_q[1] <= ONE_Q30 && r_q[1] >= -ONE_Q30 &&
        r_q[2] <= ONE_Q30 && r_q[2] >= -ONE_Q30 && r_q[3] <= ONE_Q30 && r_q[3] >= -ONE_Q30)
    `QOF_ASSERT_IMP(a_mul_in_wait, i_clk, i_rst_n, w_mul_vld, r_state == S_WAIT)
    `QOF_ASSERT_IMP(a_norm_in_norm, i_clk, i_rst_n, w_nsts.done,
        r_state == S_ANORM || r_state == S_SNORM || r_state == S_QNORM)
    `QOF_ASSERT_NXT(a_out_once, i_clk, i_rst_n, o_quat.valid && o_quat.ready, !o_quat.valid)

endmodule
`default_nettype wire

// File: rtl/core/qof_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qof_mul
// shared multiply-accumulate with rounding shift, three register stages
// ---------------------------------------------------------------------------
module qof_mul import qof_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mul_req             i_req,
    output logic                 o_vld,
    output logic signed [AW-1:0] o_res
);

    logic signed [AW+BW-1:0] w_prod;
    logic signed [63:0]      r_p;
    logic                    r_v1, r_neg1, r_first1, r_last1;
    t_rnd                    r_rnd1;
    logic signed [63:0]      r_acc;
    logic                    r_v2, r_last2;
    t_rnd                    r_rnd2;
    logic signed [63:0]      w_add;
    logic signed [63:0]      w_half;
    logic [5:0]              w_amt;
    logic signed [63:0]      w_rnd;
    logic                    r_vld;
    logic signed [AW-1:0]    r_res;

    assign w_prod = i_req.a * i_req.b;
    assign w_add  = r_neg1 ? -r_p : r_p;

    always_comb begin
        case (r_rnd2)
            RND_12:  w_amt = 6'd12;
            RND_16:  w_amt = 6'd16;
            RND_24:  w_amt = 6'd24;
            default: w_amt = 6'd30;
        endcase
        w_half = 64'sd1 <<< (w_amt - 6'd1);
        // round half up, arithmetic shift floors
        w_rnd  = (r_acc + w_half) >>> w_amt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_v1  <= i_req.vld;
            r_v2  <= r_v1;
            r_vld <= r_v2 && r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= w_prod[63:0];
        r_neg1   <= i_req.neg;
        r_first1 <= i_req.first;
        r_last1  <= i_req.last;
        r_rnd1   <= i_req.rnd;
        if (r_v1) begin
            r_acc <= (r_first1 ? 64'sd0 : r_acc) + w_add;
        end
        r_last2 <= r_last1;
        r_rnd2  <= r_rnd1;
        if (r_v2 && r_last2) begin
            r_res <= w_rnd[AW-1:0];
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule
`default_nettype wire

// File: rtl/core/qof_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qof_norm
// vector unitizer: range shift, sum of squares, bit-serial root and divide
// ---------------------------------------------------------------------------
module qof_norm import qof_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_nvec     i_vec,
    output t_norm_sts o_sts,
    output t_qvec     o_vec
);

    t_nstate            r_st, n_st;
    logic [NW-1:0]      r_mag [4];
    logic               r_neg [4];
    logic [NW-1:0]      r_max;
    logic [NW-1:0]      w_m01, w_m23, w_max;
    logic [4:0]         r_cnt;
    logic [59:0]        r_sq;
    logic [61:0]        r_sum;
    logic [61:0]        r_x;
    logic [61:0]        r_root;
    logic [61:0]        w_bit;
    logic [61:0]        w_trial;
    logic               w_sq_ge;
    logic [32:0]        r_rem;
    logic               w_dv_ge;
    logic [32:0]        w_rem_sub;
    logic [30:0]        r_quo;
    logic [30:0]        w_u;
    logic signed [QW-1:0] w_us;
    logic [1:0]         r_idx;
    logic               r_done, r_ok;
    t_qvec              r_out;

    assign w_m01   = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign w_m23   = (r_mag[2] > r_mag[3]) ? r_mag[2] : r_mag[3];
    assign w_max   = (w_m01 > w_m23) ? w_m01 : w_m23;
    assign w_bit   = 62'd1 << {r_cnt, 1'b0};
    assign w_trial = r_root + w_bit;
    assign w_sq_ge = r_x >= w_trial;
    assign w_dv_ge = r_rem >= {1'b0, r_root[31:0]};
    assign w_rem_sub = w_dv_ge ? (r_rem - {1'b0, r_root[31:0]}) : r_rem;
    assign w_u     = (r_quo > 31'(ONE_Q30)) ? 31'(ONE_Q30) : r_quo;
    assign w_us    = $signed({1'b0, w_u});

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            N_IDLE:  if (i_start) n_st = N_MAX;
            N_MAX:   n_st = (w_max == '0) ? N_IDLE : N_SHIFT;
            N_SHIFT: if (r_max[NW-1:30] == '0 && r_max[29]) n_st = N_SQ;
            N_SQ:    if (r_cnt == 5'd4) n_st = N_SQRT;
            N_SQRT:  if (r_cnt == 5'd0) n_st = N_DINIT;
            N_DINIT: n_st = N_DIV;
            N_DIV:   if (r_cnt == 5'd0) n_st = N_DST;
            N_DST:   n_st = (r_idx == 2'd3) ? N_IDLE : N_DINIT;
            default: n_st = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= N_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == N_MAX && w_max == '0) || (r_st == N_DST && r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            N_IDLE: begin
                for (int i = 0; i < 4; i++) begin
                    r_neg[i] <= i_vec[i] < 0;
                    r_mag[i] <= (i_vec[i] < 0) ? NW'(-i_vec[i]) : NW'(i_vec[i]);
                end
            end
            N_MAX: begin
                r_max <= w_max;
                r_ok  <= w_max != '0;
            end
            N_SHIFT: begin
                if (r_max[NW-1:30] != '0) begin
                    r_max <= r_max >> 1;
                    for (int i = 0; i < 4; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (!r_max[29]) begin
                    r_max <= r_max << 1;
                    for (int i = 0; i < 4; i++) r_mag[i] <= r_mag[i] << 1;
                end
                r_cnt <= 5'd0;
                r_sum <= '0;
            end
            N_SQ: begin
                if (r_cnt != 5'd4) r_sq <= r_mag[r_cnt[1:0]][29:0] * r_mag[r_cnt[1:0]][29:0];
                if (r_cnt != 5'd0) r_sum <= r_sum + 62'(r_sq);
                if (r_cnt == 5'd4) begin
                    r_x    <= r_sum + 62'(r_sq);
                    r_root <= '0;
                    r_cnt  <= 5'd30;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            N_SQRT: begin
                // one result bit per cycle, floor root
                if (w_sq_ge) begin
                    r_x    <= r_x - w_trial;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_cnt <= r_cnt - 5'd1;
                r_idx <= 2'd0;
            end
            N_DINIT: begin
                r_rem <= 33'(r_mag[r_idx]);
                r_quo <= '0;
                r_cnt <= 5'd30;
            end
            N_DIV: begin
                r_rem <= {w_rem_sub[31:0], 1'b0};
                r_quo <= {r_quo[29:0], w_dv_ge};
                r_cnt <= r_cnt - 5'd1;
            end
            N_DST: begin
                r_out[r_idx] <= r_neg[r_idx] ? -w_us : w_us;
                r_idx        <= r_idx + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_sts.done = r_done;
    assign o_sts.ok   = r_ok;
    assign o_vec      = r_out;

endmodule
`default_nettype wire

// File: tb/quaternion_orientation_filter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_orientation_filter_tb
// drives imu samples under random gaps and output stalls, predicts each
// updated quaternion in fixed point and checks every result field by field
// ---------------------------------------------------------------------------
module quaternion_orientation_filter_tb import qof_pkg::*;;

    typedef struct {
        logic signed [15:0] gx, gy, gz, ax, ay, az;
    } t_imu_sample;

    typedef struct {
        logic signed [31:0] w, x, y, z;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = CFG_BETA;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    qof_imu_if  imu_ch();
    qof_quat_if quat_ch();

    quaternion_orientation_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_imu      (imu_ch.sink),
        .o_quat     (quat_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        imu_ch.valid   = 1'b0;
        imu_ch.gyro_x  = '0;
        imu_ch.gyro_y  = '0;
        imu_ch.gyro_z  = '0;
        imu_ch.accel_x = '0;
        imu_ch.accel_y = '0;
        imu_ch.accel_z = '0;
        quat_ch.ready  = 1'b0;
    end

    // orientation predictor state
    longint orient[4];
    longint gain_q16;
    longint period_q24;
    longint vec[4];

    t_quat pending_quats[$];
    int    mismatches = 0;
    int    failures = 0;
    bit    sender_gaps_on = 1'b1;
    bit    sink_stalls_on = 1'b1;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return rnd_shift(a * b, 30);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scales vec[0..n-1] to unit length in Q1.30, false on a zero vector
    function automatic bit unit_vec(int n);
        longint unsigned mag[4];
        longint unsigned m, sum, root, u;
        m = 0;
        sum = 0;
        for (int i = 0; i < n; i++) begin
            mag[i] = vec[i] < 0 ? longint'(-vec[i]) : longint'(vec[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b0;
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < n; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < n; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < n; i++) sum = sum + mag[i] * mag[i];
        root = isqrt(sum);
        for (int i = 0; i < n; i++) begin
            u = (mag[i] << 30) / root;
            if (u > (64'd1 << 30)) u = 64'd1 << 30;
            vec[i] = vec[i] < 0 ? -longint'(u) : longint'(u);
        end
        return 1'b1;
    endfunction

    function automatic t_quat update_orientation(t_imu_sample smp);
        longint q0, q1, q2, q3, gx, gy, gz, f1, f2, rate;
        longint s[4];
        longint d[4];
        t_quat r;
        q0 = orient[0]; q1 = orient[1]; q2 = orient[2]; q3 = orient[3];
        gx = longint'(smp.gx); gy = longint'(smp.gy); gz = longint'(smp.gz);
        for (int i = 0; i < 4; i++) s[i] = 0;
        vec[0] = longint'(smp.ax);
        vec[1] = longint'(smp.ay);
        vec[2] = longint'(smp.az);
        if (unit_vec(3)) begin
            f1 = 2 * (mul_q30(q1, q3) - mul_q30(q0, q2)) - vec[0];
            f2 = 2 * (mul_q30(q0, q1) + mul_q30(q2, q3)) - vec[1];
            vec[0] = 2 * (mul_q30(f2, q1) - mul_q30(f1, q2));
            vec[1] = 2 * (mul_q30(f1, q3) + mul_q30(f2, q0));
            vec[2] = 2 * (mul_q30(f2, q3) - mul_q30(f1, q0));
            vec[3] = 2 * (mul_q30(f1, q1) + mul_q30(f2, q2));
            if (unit_vec(4)) begin
                for (int i = 0; i < 4; i++) s[i] = vec[i];
            end
        end
        d[0] = rnd_shift(-q1 * gx - q2 * gy - q3 * gz, 12);
        d[1] = rnd_shift(q0 * gx + q2 * gz - q3 * gy, 12);
        d[2] = rnd_shift(q0 * gy - q1 * gz + q3 * gx, 12);
        d[3] = rnd_shift(q0 * gz + q1 * gy - q2 * gx, 12);
        for (int i = 0; i < 4; i++) begin
            rate = d[i] - rnd_shift(gain_q16 * s[i], 16);
            vec[i] = orient[i] + rnd_shift(rate * period_q24, 24);
        end
        if (!unit_vec(4)) begin
            vec[0] = longint'(ONE_Q30);
            vec[1] = 0; vec[2] = 0; vec[3] = 0;
        end
        for (int i = 0; i < 4; i++) orient[i] = vec[i];
        r.w = vec[0][31:0]; r.x = vec[1][31:0]; r.y = vec[2][31:0]; r.z = vec[3][31:0];
        return r;
    endfunction

    task automatic send_sample(t_imu_sample smp);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            imu_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        imu_ch.valid   <= 1'b1;
        imu_ch.gyro_x  <= smp.gx;
        imu_ch.gyro_y  <= smp.gy;
        imu_ch.gyro_z  <= smp.gz;
        imu_ch.accel_x <= smp.ax;
        imu_ch.accel_y <= smp.ay;
        imu_ch.accel_z <= smp.az;
        do @(posedge i_clk); while (!imu_ch.ready);
        pending_quats.push_back(update_orientation(smp));
    endtask

    task automatic drain_results();
        imu_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_quats.size() != 0) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BETA) gain_q16 = longint'(data[15:0]);
        else if (idx == CFG_PERIOD) period_q24 = longint'(data);
    endtask

    function automatic t_imu_sample mk(int gx, int gy, int gz, int ax, int ay, int az);
        t_imu_sample smp;
        smp.gx = 16'(gx); smp.gy = 16'(gy); smp.gz = 16'(gz);
        smp.ax = 16'(ax); smp.ay = 16'(ay); smp.az = 16'(az);
        return smp;
    endfunction

    function automatic t_imu_sample random_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            // plausible motion: gravity mostly along z, modest rates
            return mk($signed($urandom_range(0, 4000)) - 2000,
                      $signed($urandom_range(0, 4000)) - 2000,
                      $signed($urandom_range(0, 4000)) - 2000,
                      $signed($urandom_range(0, 8000)) - 4000,
                      $signed($urandom_range(0, 8000)) - 4000,
                      $signed($urandom_range(8000, 20000)));
        end else if (kind < 9) begin
            return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        // zero accel with random rates
        return mk($urandom, $urandom, $urandom, 0, 0, 0);
    endfunction

    // sink side: random stall after each transaction
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            if (pending_quats.size() == 0) begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected quaternion transaction %h %h %h %h",
                             quat_ch.quat_w, quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z);
                mismatches++;
            end else begin
                exp_q = pending_quats.pop_front();
                if (exp_q.w !== quat_ch.quat_w || exp_q.x !== quat_ch.quat_x ||
                    exp_q.y !== quat_ch.quat_y || exp_q.z !== quat_ch.quat_z) begin
                    failures++;
                    if (mismatches < 10)
                        $display("quat mismatch exp %h %h %h %h got %h %h %h %h",
                                 exp_q.w, exp_q.x, exp_q.y, exp_q.z, quat_ch.quat_w,
                                 quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z);
                    mismatches++;
                end
            end
            stall_left = sink_stalls_on ? $urandom_range(0, 5) : 0;
        end
        if (stall_left > 0) begin
            quat_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            quat_ch.ready <= 1'b1;
        end
    end

    task automatic test_directed_cases();
        send_sample(mk(0, 0, 0, 0, 0, 16384));           // level and still
        send_sample(mk(0, 0, 0, 0, 0, 0));               // zero accel
        send_sample(mk(32767, 32767, 32767, 0, 0, 0));
        send_sample(mk(-32768, -32768, -32768, 0, 0, -1));
        send_sample(mk(32767, -32768, 0, 32767, -32768, 32767));
        send_sample(mk(-32768, 32767, -1, -32768, 32767, -32768));
        send_sample(mk(1, -1, 1, 1, 0, 0));
        send_sample(mk(0, 0, 0, 0, 1, 0));
        send_sample(mk(100, 200, -300, 1000, -2000, 16000));
        send_sample(mk(-1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_BETA, 24'hFF_0000);                 // upper bits dropped: beta 0
        send_sample(mk(500, -500, 800, 3000, -3000, 15000));
        write_reg(CFG_BETA, 24'h00_FFFF);
        send_sample(mk(500, -500, 800, 3000, -3000, 15000));
        send_sample(mk(0, 0, 0, 32767, 0, 0));
        write_reg(CFG_PERIOD, 24'hFF_FFFF);
        send_sample(mk(32767, -32768, 32767, -32768, 32767, 0));
        send_sample(mk(-200, 300, 100, 0, 0, 0));
        write_reg(CFG_PERIOD, 24'd1);
        send_sample(mk(32767, 32767, 32767, 100, 100, 100));
        write_reg(CFG_PERIOD, 24'd0);                     // no integration
        send_sample(mk(32767, 32767, 32767, 100, -100, 100));
        write_reg(2'd2, 24'h12_3456);                     // no such register
        write_reg(2'd3, 24'hFF_FFFF);
        send_sample(mk(10, 20, 30, 40, 50, 60));
    endtask

    task automatic test_random_motion(logic [15:0] beta, logic [23:0] period, int count);
        write_reg(CFG_BETA, {8'h00, beta});
        write_reg(CFG_PERIOD, period);
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) begin
                sender_gaps_on = 1'b0;
                sink_stalls_on = 1'b0;
            end else if (n == count / 2) begin
                sender_gaps_on = 1'b1;
                sink_stalls_on = 1'b1;
                drain_results();                          // hold off until all back
            end
            send_sample(random_sample());
        end
    endtask

    initial begin
        orient[0] = longint'(ONE_Q30);
        orient[1] = 0; orient[2] = 0; orient[3] = 0;
        gain_q16   = 6554;
        period_q24 = 167772;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_register_extremes();
        test_random_motion(16'd6554, 24'd167772, 470);
        test_random_motion(16'hFFFF, 24'd1677721, 450);
        test_random_motion(16'd0, 24'hFF_FFFF, 450);
        test_random_motion(16'd300, 24'd16777, 460);
        drain_results();
        repeat (1000) @(posedge i_clk);
        if (failures == 0 && pending_quats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
